@@ design/lmrd_pkg.sv @@
package lmrd_pkg;

  // Row memory depth; taken to be a power of two so that column indices wrap.
  localparam int MAX_WIDTH   = 1024;
  localparam int MARKER_SPAN = 10;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int CNT_W       = COL_W + 1;

  localparam int PIX_W       = 24;
  localparam int ROW_W       = 10;
  localparam int SUM_W       = 10;
  localparam int EDGE_W      = 10;
  localparam int LINE_W      = 11;

  localparam int CFG_WIDTH_W = 11;
  localparam int CFG_HGT_W   = 11;
  localparam int CFG_LVL_W   = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  // Wide enough for both the configured width and the memory depth itself.
  localparam int EXT_W = (CNT_W > CFG_WIDTH_W) ? CNT_W : CFG_WIDTH_W;

  localparam logic [CFG_WIDTH_W-1:0] RST_WIDTH  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HGT_W-1:0]   RST_HEIGHT = CFG_HGT_W'(480);
  localparam logic [CFG_LVL_W-1:0]   RST_FLOOR  = CFG_LVL_W'(180);
  localparam logic [CFG_LVL_W-1:0]   RST_DELTA  = CFG_LVL_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_FLOOR,
    REG_DELTA
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PEAK,
    OP_NBR,
    OP_RISE_FIRST,
    OP_RISE
  } rd_op_t;

  typedef struct packed {
    logic [CFG_WIDTH_W-1:0] width;
    logic [CFG_HGT_W-1:0]   height;
    logic [CFG_LVL_W-1:0]   floor;
    logic [CFG_LVL_W-1:0]   delta;
  } cfg_t;

  typedef struct packed {
    logic   write_en;
    logic   capture;
    logic   ptr_clr;
    logic   ptr_rise;
    logic   ptr_inc;
    logic   rd_en;
    logic   rd_nbr;
    rd_op_t op;
    logic   side;
    logic   commit;
  } cmd_t;

  typedef struct packed {
    logic scan_empty;
    logic scan_last;
    logic gate_ok;
    logic rise_last;
    logic hit_l;
    logic hit_r;
  } sts_t;

endpackage

@@ design/lane_marker_row_detect.sv @@
// Lane marker row detector. Pixels stream in one per cycle while in_ready is
// high, and the sum R+G+B of each is written to a row memory. The request
// flagged end_of_row starts a search: one memory read a cycle over columns 0
// to w-2, then a drain state for the last read, then for each half a gate
// check and, if that passes, 13 reads for the side contrast and the
// rising-edge window. No pixel is taken until the search is done and its
// results have gone out; a result that waits for out_ready holds the input
// too. The single read port of the row memory sets the length of the search.
// Up to two results follow, left before right, the final one flagged last.
// Row memory entries are undefined until written, so there is no clearing
// pass after reset.
module lane_marker_row_detect
  import lmrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic [ROW_W-1:0]      in_row,
  input  logic                  in_end_of_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_side,
  output logic [LINE_W-1:0]     out_line_row,
  output logic [EDGE_W-1:0]     out_edge_column,
  output logic                  out_last
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= RST_WIDTH;
      cfg_r.height <= RST_HEIGHT;
      cfg_r.floor  <= RST_FLOOR;
      cfg_r.delta  <= RST_DELTA;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  cfg_r.width  <= CFG_WIDTH_W'(cfg_wdata);
        REG_HEIGHT: cfg_r.height <= CFG_HGT_W'(cfg_wdata);
        REG_FLOOR:  cfg_r.floor  <= CFG_LVL_W'(cfg_wdata);
        REG_DELTA:  cfg_r.delta  <= CFG_LVL_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  lmrd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_end_of_row (in_end_of_row),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  lmrd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_pixel        (in_pixel),
    .in_row          (in_row),
    .cmd             (cmd),
    .sts             (sts),
    .out_side        (out_side),
    .out_line_row    (out_line_row),
    .out_edge_column (out_edge_column),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  // No pixel is taken while a result is on offer.
  a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  // A left result that is not last is followed straight away by the right one.
  a_right_follows_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_side))
    else $error("right result missing after a non-final left result");

  // The right result always closes the row.
  a_right_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_side) |-> out_last)
    else $error("right result not flagged last");
`endif

endmodule

@@ design/lmrd_ctrl.sv @@
module lmrd_ctrl
  import lmrd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_end_of_row,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IN,
    S_SCAN,
    S_DRAIN,
    S_JUDGE,
    S_RISE0,
    S_RISE,
    S_RWAIT,
    S_DECIDE,
    S_OUT_L,
    S_OUT_R
  } state_t;

  state_t state_r, state_nxt;
  logic   side_r, side_nxt;
  logic   accept;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IN);

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.side  = side_r;
    out_valid = 1'b0;
    case (state_r)
      S_IN: begin
        cmd.write_en = accept;
        if (accept && in_end_of_row) begin
          cmd.capture = 1'b1;
          cmd.ptr_clr = 1'b1;
          side_nxt    = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_empty) begin
          state_nxt = S_JUDGE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.op      = OP_PEAK;
          cmd.ptr_inc = 1'b1;
          if (sts.scan_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_JUDGE;
      end
      S_JUDGE: begin
        if (sts.gate_ok) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_nbr   = 1'b1;
          cmd.op       = OP_NBR;
          cmd.ptr_rise = 1'b1;
          state_nxt    = S_RISE0;
        end else if (side_r) begin
          state_nxt = S_OUT_L;
        end else begin
          side_nxt = 1'b1;
        end
      end
      S_RISE0: begin
        cmd.rd_en   = 1'b1;
        cmd.op      = OP_RISE_FIRST;
        cmd.ptr_inc = 1'b1;
        state_nxt   = S_RISE;
      end
      S_RISE: begin
        cmd.rd_en   = 1'b1;
        cmd.op      = OP_RISE;
        cmd.ptr_inc = 1'b1;
        if (sts.rise_last) begin
          state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.commit = 1'b1;
        if (side_r) begin
          state_nxt = S_OUT_L;
        end else begin
          side_nxt  = 1'b1;
          state_nxt = S_JUDGE;
        end
      end
      S_OUT_L: begin
        cmd.side  = 1'b0;
        out_valid = sts.hit_l;
        if (!sts.hit_l || out_ready) begin
          state_nxt = S_OUT_R;
        end
      end
      S_OUT_R: begin
        cmd.side  = 1'b1;
        out_valid = sts.hit_r;
        if (!sts.hit_r || out_ready) begin
          state_nxt = S_IN;
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
    end
  end

endmodule

@@ design/lmrd_datapath.sv @@
module lmrd_datapath
  import lmrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic [ROW_W-1:0]  in_row,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_side,
  output logic [LINE_W-1:0] out_line_row,
  output logic [EDGE_W-1:0] out_edge_column,
  output logic              out_last
);

  logic [SUM_W-1:0] mem [MAX_WIDTH];

  logic [COL_W-1:0] col_cnt_r;
  logic [COL_W-1:0] ptr_r;
  logic [COL_W-1:0] tag_r;
  rd_op_t           op_q_r;
  logic [SUM_W-1:0] rd_data_r;

  logic [SUM_W-1:0] lsum_r, rsum_r;
  logic [COL_W-1:0] lcol_r, rcol_r;
  logic             nbr_ok_r, lft_ok_r;
  logic [SUM_W-1:0] prev_r, best_r;
  logic [COL_W-1:0] prev_col_r, bidx_r;
  logic             hit_l_r, hit_r_r;
  logic [COL_W-1:0] edge_l_r, edge_r_r;
  logic [ROW_W-1:0] row_r;

  logic [SUM_W-1:0] pix_sum;
  logic [EXT_W-1:0] w_ext, w_eff, half;
  logic [COL_W-1:0] sel_col, nbr_addr, rd_addr;
  logic [SUM_W-1:0] sel_sum;
  logic [SUM_W:0]   contrast_lim;
  logic [SUM_W:0]   rise_lim;

  assign pix_sum = SUM_W'(in_pixel[7:0]) + SUM_W'(in_pixel[15:8]) + SUM_W'(in_pixel[23:16]);

  // Widths above the memory depth are clipped to it.
  assign w_ext = EXT_W'(cfg.width);
  assign w_eff = (w_ext > EXT_W'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH) : w_ext;
  assign half  = w_eff >> 1;

  assign sel_col  = cmd.side ? rcol_r : lcol_r;
  assign sel_sum  = cmd.side ? rsum_r : lsum_r;
  assign nbr_addr = sel_col + COL_W'(MARKER_SPAN);
  assign rd_addr  = cmd.rd_nbr ? nbr_addr : ptr_r;

  assign contrast_lim = {1'b0, rd_data_r} + {1'b0, cfg.delta};
  assign rise_lim     = {1'b0, prev_r} + {1'b0, best_r};

  assign sts.scan_empty = (w_eff < EXT_W'(2));
  assign sts.scan_last  = (EXT_W'(ptr_r) == (w_eff - EXT_W'(2)));
  assign sts.gate_ok    = (sel_col > COL_W'(MARKER_SPAN)) &&
                          (!cmd.side ||
                           ((EXT_W'(sel_col) + EXT_W'(MARKER_SPAN)) < w_eff));
  assign sts.rise_last  = (ptr_r == sel_col + COL_W'(1));
  assign sts.hit_l      = hit_l_r;
  assign sts.hit_r      = hit_r_r;

  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      mem[col_cnt_r] <= pix_sum;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      tag_r     <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (cmd.ptr_rise) begin
      ptr_r <= sel_col - COL_W'(MARKER_SPAN);
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      op_q_r    <= OP_NONE;
      hit_l_r   <= 1'b0;
      hit_r_r   <= 1'b0;
      lsum_r    <= '0;
      lcol_r    <= '0;
      rsum_r    <= '0;
      rcol_r    <= '0;
    end else begin
      op_q_r <= cmd.rd_en ? cmd.op : OP_NONE;
      if (cmd.capture) begin
        col_cnt_r <= '0;
      end else if (cmd.write_en) begin
        col_cnt_r <= col_cnt_r + COL_W'(1);
      end
      if (cmd.capture) begin
        lsum_r  <= '0;
        lcol_r  <= '0;
        rsum_r  <= '0;
        rcol_r  <= '0;
        hit_l_r <= 1'b0;
        hit_r_r <= 1'b0;
      end else if (op_q_r == OP_PEAK && rd_data_r >= cfg.floor) begin
        if (EXT_W'(tag_r) < half) begin
          if (rd_data_r > lsum_r) begin
            lsum_r <= rd_data_r;
            lcol_r <= tag_r;
          end
        end else if (rd_data_r > rsum_r) begin
          rsum_r <= rd_data_r;
          rcol_r <= tag_r;
        end
      end
      if (cmd.commit) begin
        if (cmd.side) begin
          hit_r_r <= nbr_ok_r && lft_ok_r;
        end else begin
          hit_l_r <= nbr_ok_r && lft_ok_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row;
    end
    if (cmd.commit) begin
      if (cmd.side) begin
        edge_r_r <= bidx_r;
      end else begin
        edge_l_r <= bidx_r;
      end
    end
    case (op_q_r)
      OP_NBR: begin
        nbr_ok_r <= {1'b0, sel_sum} > contrast_lim;
      end
      OP_RISE_FIRST: begin
        lft_ok_r   <= {1'b0, sel_sum} > contrast_lim;
        prev_r     <= rd_data_r;
        prev_col_r <= tag_r;
        best_r     <= '0;
        bidx_r     <= '0;
      end
      OP_RISE: begin
        // Only a strictly larger rise replaces the best, so the first one wins ties.
        if ({1'b0, rd_data_r} > rise_lim) begin
          best_r <= rd_data_r - prev_r;
          bidx_r <= prev_col_r;
        end
        prev_r     <= rd_data_r;
        prev_col_r <= tag_r;
      end
      default: begin
      end
    endcase
  end

  assign out_side        = cmd.side;
  assign out_line_row    = cfg.height - LINE_W'(row_r);
  assign out_edge_column = EDGE_W'(cmd.side ? edge_r_r : edge_l_r);
  assign out_last        = cmd.side || !hit_r_r;

endmodule

@@ bench/testbench.sv @@
module testbench;
  import lmrd_pkg::*;

  localparam int RANDOM_ITEMS  = 250;
  localparam int SETTLE_CYCLES = MAX_WIDTH + 80;
  localparam int ROW_BUF_LEN   = MAX_WIDTH + 32;
  localparam int DIR_ROWS      = 12;
  localparam int SUM_MAX       = 765;

  typedef struct packed {
    logic              side;
    logic [LINE_W-1:0] line_row;
    logic [EDGE_W-1:0] edge_column;
    logic              last;
  } marker_t;

  // One directed row: configuration, row shape and, where obvious, the markers it yields.
  typedef struct {
    int      width;
    int      height;
    int      floor_lvl;
    int      delta_lvl;
    int      len;
    int      bg;
    int      lcol;
    int      lval;
    int      rcol;
    int      rval;
    int      xcol;
    int      xval;
    int      rownum;
    bit      typed;
    int      n_typed;
    marker_t t0;
    marker_t t1;
  } row_case_t;

  localparam marker_t NO_M = '0;

  row_case_t dir_rows [DIR_ROWS] = '{
    '{640, 480, 180, 30, 0, 50, 100, 300, 500, 400, -1, 0, 0, 1'b1, 2,
      '{1'b0, 11'd480, 10'd99, 1'b0}, '{1'b1, 11'd480, 10'd499, 1'b1}},
    '{22, 1024, 0, 0, 0, 0, -1, 0, -1, 0, -1, 0, 7, 1'b1, 0, NO_M, NO_M},
    '{22, 1024, 0, 0, 0, 0, -1, 0, 11, 765, -1, 0, 1023, 1'b1, 1,
      '{1'b1, 11'd1, 10'd10, 1'b1}, NO_M},
    '{22, 1024, 0, 0, 0, 0, 10, 765, 12, 700, -1, 0, 3, 1'b1, 0, NO_M, NO_M},
    '{64, 1, 765, 0, 0, 0, 20, 765, 40, 765, -1, 0, 5, 1'b1, 2,
      '{1'b0, 11'd2044, 10'd19, 1'b0}, '{1'b1, 11'd2044, 10'd39, 1'b1}},
    '{64, 1, 765, 0, 0, 0, 20, 764, 40, 765, 63, 765, 1, 1'b1, 1,
      '{1'b1, 11'd0, 10'd39, 1'b1}, NO_M},
    '{64, 1, 0, 765, 0, 0, 20, 765, 40, 765, -1, 0, 9, 1'b1, 0, NO_M, NO_M},
    '{64, 300, 100, 20, 0, 30, 15, 500, 45, 600, 18, 500, 299, 1'b0, 0, NO_M, NO_M},
    '{64, 300, 100, 20, 30, 40, 20, 400, -1, 0, -1, 0, 100, 1'b0, 0, NO_M, NO_M},
    '{64, 300, 100, 20, 0, 0, 31, 300, 32, 500, -1, 0, 50, 1'b0, 0, NO_M, NO_M},
    '{64, 300, 100, 20, 0, 20, 11, 250, 53, 260, 63, 700, 0, 1'b0, 0, NO_M, NO_M},
    '{63, 1000, 50, 10, 0, 20, 15, 200, 40, 250, -1, 0, 999, 1'b0, 0, NO_M, NO_M}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel;
  logic [ROW_W-1:0]      in_row;
  logic                  in_end_of_row;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_side;
  logic [LINE_W-1:0]     out_line_row;
  logic [EDGE_W-1:0]     out_edge_column;
  logic                  out_last;

  lane_marker_row_detect dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel        (in_pixel),
    .in_row          (in_row),
    .in_end_of_row   (in_end_of_row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_side        (out_side),
    .out_line_row    (out_line_row),
    .out_edge_column (out_edge_column),
    .out_last        (out_last)
  );

  // Shadow of the block: row sums, write column and the current settings.
  int      sums_shadow [MAX_WIDTH];
  int      wr_col = 0;
  int      cur_width = 640;
  int      cur_height = 480;
  int      cur_floor = 180;
  int      cur_delta = 30;
  int      written_len = 0;
  int      row_buf [ROW_BUF_LEN];
  marker_t found_buf [2];
  marker_t marker_q [$];
  marker_t want_m;
  int      fails = 0;

  function automatic int sum_at(input int c);
    if (c < 0) return 0;
    return sums_shadow[c % MAX_WIDTH];
  endfunction

  function automatic void peak_search(input int lo, input int hi, output int psum,
                                      output int pcol);
    int v;
    psum = 0;
    pcol = 0;
    for (int c = lo; c < hi; c++) begin
      v = sum_at(c);
      if (v >= cur_floor && v > psum) begin
        psum = v;
        pcol = c;
      end
    end
  endfunction

  function automatic bit marker_ok(input int psum, input int pcol, input bit right_half,
                                   input int w, output int rise_col);
    int best, bidx, d;
    best = 0;
    bidx = 0;
    rise_col = 0;
    if (pcol <= MARKER_SPAN) return 1'b0;
    if (right_half && (w - pcol) <= MARKER_SPAN) return 1'b0;
    if (!(psum - sum_at(pcol - MARKER_SPAN) > cur_delta)) return 1'b0;
    if (!(psum - sum_at(pcol + MARKER_SPAN) > cur_delta)) return 1'b0;
    for (int i = pcol - MARKER_SPAN; i <= pcol; i++) begin
      d = sum_at(i + 1) - sum_at(i);
      if (d > best) begin
        best = d;
        bidx = i;
      end
    end
    rise_col = bidx;
    return 1'b1;
  endfunction

  // Takes one accepted pixel; at the end of a row fills found_buf and returns the count.
  function automatic int predict_markers(input logic [PIX_W-1:0] px, input logic [ROW_W-1:0] rw,
                                         input logic eor);
    int w, half, lsum, lcol, rsum, rcol, ledge, redge, n;
    bit hit_l, hit_r;
    logic [LINE_W-1:0] line;
    sums_shadow[wr_col] = int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16]);
    wr_col = (wr_col + 1) % MAX_WIDTH;
    if (!eor) return 0;
    wr_col = 0;
    w = (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
    half = w / 2;
    peak_search(0, half, lsum, lcol);
    peak_search(half, w - 1, rsum, rcol);
    hit_l = marker_ok(lsum, lcol, 1'b0, w, ledge);
    hit_r = marker_ok(rsum, rcol, 1'b1, w, redge);
    line = LINE_W'(cur_height - int'(rw));
    n = 0;
    if (hit_l) begin
      found_buf[n] = '{1'b0, line, EDGE_W'(ledge), !hit_r};
      n++;
    end
    if (hit_r) begin
      found_buf[n] = '{1'b1, line, EDGE_W'(redge), 1'b1};
      n++;
    end
    return n;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Splits a brightness sum into three random colour bytes.
  function automatic logic [PIX_W-1:0] pack_sum(input int s);
    int r, g, b;
    r = $urandom_range((s < 255) ? s : 255, (s > 510) ? s - 510 : 0);
    g = $urandom_range((s - r < 255) ? s - r : 255, (s - r > 255) ? s - r - 255 : 0);
    b = s - r - g;
    return {8'(b), 8'(g), 8'(r)};
  endfunction

  function automatic void put_marker(input int p, input int bg_max);
    int lo, pv, k;
    lo = bg_max + cur_delta + 1;
    if (lo > SUM_MAX) lo = SUM_MAX;
    if (lo < cur_floor) lo = cur_floor;
    if ($urandom_range(0, 4) == 0) lo = cur_floor;
    pv = $urandom_range(SUM_MAX, lo);
    k = $urandom_range(0, 5);
    for (int j = 1; j <= k && p - j >= 0; j++) row_buf[p - j] = pv * (k + 1 - j) / (k + 1);
    row_buf[p] = pv;
  endfunction

  function automatic int pick_col(input int lo, input int hi, input int w);
    if (lo > hi || $urandom_range(0, 9) == 0) return $urandom_range(0, w - 1);
    return $urandom_range(hi, lo);
  endfunction

  // Background, mostly low, with a bright marker, usually contrasting, in most halves.
  function automatic void shape_marked(input int w, input int span);
    int bg_max, half;
    bg_max = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SUM_MAX) : $urandom_range(0, 120);
    for (int c = 0; c < span; c++) row_buf[c] = $urandom_range(0, bg_max);
    half = w / 2;
    if ($urandom_range(0, 4) != 0) put_marker(pick_col(MARKER_SPAN + 1, half - 1, w), bg_max);
    if ($urandom_range(0, 4) != 0) put_marker(pick_col(half, w - MARKER_SPAN - 1, w), bg_max);
  endfunction

  task automatic put_reg(input reg_idx_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic apply_cfg(input int w, input int h, input int f, input int d);
    put_reg(REG_WIDTH, w);
    put_reg(REG_HEIGHT, h);
    put_reg(REG_FLOOR, f);
    put_reg(REG_DELTA, d);
    cfg_we     <= 1'b0;
    cur_width  = w;
    cur_height = h;
    cur_floor  = f;
    cur_delta  = d;
  endtask

  // Waits for every outstanding marker, then lets a rows-worth search run out.
  task automatic settle();
    in_valid <= 1'b0;
    while (marker_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_row(input int len, input int rownum, input bit typed, input int n_typed,
                          input marker_t t0, input marker_t t1);
    int n, gap;
    bit relaxed;
    logic [PIX_W-1:0] px;
    logic [ROW_W-1:0] rw;
    logic eor;
    relaxed = ($urandom_range(0, 3) == 0);
    for (int c = 0; c < len; c++) begin
      eor = (c == len - 1);
      px  = pack_sum(row_buf[c]);
      rw  = eor ? ROW_W'(rownum) : ROW_W'($urandom_range(0, 1023));
      gap = (!relaxed && $urandom_range(0, 3) == 0) ? idle_len() : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_pixel      <= px;
      in_row        <= rw;
      in_end_of_row <= eor;
      do @(posedge clk); while (!in_ready);
      n = predict_markers(px, rw, eor);
      if (typed) begin
        if (eor && n_typed > 0) marker_q.insert(marker_q.size(), t0);
        if (eor && n_typed > 1) marker_q.insert(marker_q.size(), t1);
      end else begin
        for (int k = 0; k < n; k++) marker_q.insert(marker_q.size(), found_buf[k]);
      end
    end
    if (len > written_len) written_len = (len > MAX_WIDTH) ? MAX_WIDTH : len;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, with calm stretches where every request is taken at once.
  initial begin
    int hold, calm;
    hold = 0;
    calm = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 199) == 0) calm = $urandom_range(50, 300);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (calm == 0 && $urandom_range(0, 4) == 0) begin
        hold = idle_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (marker_q.size() == 0) begin
        $error("unexpected result: side %0d line_row %0d edge_column %0d last %0d",
               out_side, out_line_row, out_edge_column, out_last);
        fails++;
      end else begin
        want_m = marker_q.pop_front();
        if (out_side !== want_m.side) begin
          $error("side: expected %0d, got %0d", want_m.side, out_side);
          fails++;
        end
        if (out_line_row !== want_m.line_row) begin
          $error("line_row: expected %0d, got %0d", want_m.line_row, out_line_row);
          fails++;
        end
        if (out_edge_column !== want_m.edge_column) begin
          $error("edge_column: expected %0d, got %0d", want_m.edge_column, out_edge_column);
          fails++;
        end
        if (out_last !== want_m.last) begin
          $error("last: expected %0d, got %0d", want_m.last, out_last);
          fails++;
        end
      end
    end
  end

  initial begin
    row_case_t rc;
    int weff, len, kind, rows, rand_items, w, h, f, d;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_WIDTH;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_pixel      = '0;
    in_row        = '0;
    in_end_of_row = 1'b0;
    for (int c = 0; c < MAX_WIDTH; c++) sums_shadow[c] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; the first runs on the settings left by reset and fills 640 columns.
    foreach (dir_rows[i]) begin
      rc = dir_rows[i];
      if (rc.width != cur_width || rc.height != cur_height || rc.floor_lvl != cur_floor ||
          rc.delta_lvl != cur_delta) begin
        settle();
        apply_cfg(rc.width, rc.height, rc.floor_lvl, rc.delta_lvl);
      end
      weff = (rc.width > MAX_WIDTH) ? MAX_WIDTH : rc.width;
      len  = (rc.len == 0) ? weff : rc.len;
      for (int c = 0; c < weff; c++) row_buf[c] = rc.bg;
      if (rc.lcol >= 0) row_buf[rc.lcol] = rc.lval;
      if (rc.rcol >= 0) row_buf[rc.rcol] = rc.rval;
      if (rc.xcol >= 0) row_buf[rc.xcol] = rc.xval;
      send_row(len, rc.rownum, rc.typed, rc.n_typed, rc.t0, rc.t1);
    end

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       w = 22;
        1:       w = $urandom_range(11, 23) * 2 + 1;
        9:       w = $urandom_range(25, 100) * 2;
        default: w = $urandom_range(11, 24) * 2;
      endcase
      if ($urandom_range(0, 9) == 0) h = ($urandom_range(0, 1) == 0) ? 1 : 1024;
      else h = $urandom_range(1, 1024);
      case ($urandom_range(0, 9))
        0:       f = 0;
        1:       f = SUM_MAX;
        2:       f = $urandom_range(300, SUM_MAX);
        default: f = $urandom_range(0, 250);
      endcase
      case ($urandom_range(0, 9))
        0:       d = 0;
        1:       d = SUM_MAX;
        default: d = $urandom_range(0, 80);
      endcase
      apply_cfg(w, h, f, d);
      rows = $urandom_range(3, 8);
      weff = (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
      repeat (rows) begin
        kind = $urandom_range(0, 99);
        len  = weff;
        if (kind < 70) begin
          shape_marked(weff, weff + 20);
        end else if (kind < 82) begin
          for (int c = 0; c < weff; c++) row_buf[c] = $urandom_range(0, SUM_MAX);
        end else if (kind < 94) begin
          // A short row leans on sums left from earlier rows, so only once they exist.
          shape_marked(weff, weff + 20);
          if (written_len >= weff) len = $urandom_range(1, weff - 1);
        end else begin
          shape_marked(weff, weff + 20);
          len = weff + $urandom_range(1, 20);
        end
        send_row(len, $urandom_range(0, 1023), 1'b0, 0, NO_M, NO_M);
        rand_items += len;
      end
    end

    in_valid <= 1'b0;
    while (marker_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
